// File: rtl/tkv_pkg.sv
package tkv_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [KEY_W-1:0] EMPTY_KEY = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // capture the input transfer, rewind the scan
        logic scan_en;  // advance the scan by one slot
        logic commit;   // update the table and load the result register
    } tkv_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_count;   // command on the input port is a count
        logic scan_done;  // match seen or every slot below fill examined
        logic out_free;   // result register can take a new result
    } tkv_stat_t;

endpackage

// File: rtl/tombstone_key_value_table.sv
// Tombstone key/value table: TABLE_DEPTH slots of 16-bit key and 32-bit value,
// searched by linear scan over slots below the fill level. Key 0xFFFF marks
// an empty slot.
// Input channel (in_valid/in_stall) carries command, entry_key, entry_value;
// a transfer happens when in_valid is high and in_stall low. Commands:
// append, remove, lookup, count. Every command yields one result on the
// output channel (out_valid/out_stall): status, read_value, live_count.
// Sequence: the input transfer starts the scan, which reads one slot a cycle
// through the registered read port of the key/value memory, compares each
// slot once its read returns and ends on a match or when every slot below
// the fill level has been examined; a commit step then updates the table and
// loads the result register. A count skips the scan and goes straight to
// its commit step.
// One command is in flight at a time; in_stall stays high from the transfer
// until its result is committed. The next command is taken while an earlier
// result still waits in the output register.
// When the receiver stalls, the result register holds and a finished command
// waits in its commit step until that register drains.
// Reset clears the fill level, live count and output valid; table memory
// contents are not cleared, since only slots below the fill level are read.
module tombstone_key_value_table
    import tkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [KEY_W-1:0]    entry_key,
    input  logic [VAL_W-1:0]    entry_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VAL_W-1:0]    read_value,
    output logic [LIVE_W-1:0]   live_count
);

    tkv_ctrl_t ctrl;
    tkv_stat_t stat;

    // Sequencer: capture, scan, commit.
    tkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Table memories, scan compare, counters and result register.
    tkv_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (command),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .live_count  (live_count)
    );

endmodule

// File: rtl/tkv_ctrl.sv
module tkv_ctrl
    import tkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tkv_stat_t stat,
    output tkv_ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        ctrl.start   = 1'b0;
        ctrl.scan_en = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.start = 1'b1;
                    state_next = stat.is_count ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result register drains
                if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tkv_datapath.sv
module tkv_datapath
    import tkv_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tkv_ctrl_t           ctrl,
    output tkv_stat_t           stat,
    input  logic [CMD_W-1:0]    command,
    input  logic [KEY_W-1:0]    entry_key,
    input  logic [VAL_W-1:0]    entry_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VAL_W-1:0]    read_value,
    output logic [LIVE_W-1:0]   live_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [CW-1:0]       addr_reg;
    logic [AW-1:0]       addr_p_reg;
    logic                pend_reg;
    logic [KEY_W-1:0]    key_rd_reg;
    logic [VAL_W-1:0]    val_rd_reg;
    logic                found_reg;
    logic [AW-1:0]       idx_reg;
    logic [VAL_W-1:0]    val_found_reg;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic [CW-1:0]       live_reg;
    logic [CW-1:0]       live_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [VAL_W-1:0]    read_value_reg;
    logic [VAL_W-1:0]    read_value_next;
    logic [LIVE_W-1:0]   live_count_reg;

    logic [KEY_W-1:0] search_key;
    logic             issue;
    logic             match;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;
    logic             key_live;

    assign search_key = (cmd_reg == CMD_APPEND) ? EMPTY_KEY : key_reg;
    assign issue      = ctrl.scan_en && (addr_reg < fill_reg);
    assign match      = pend_reg && (key_rd_reg == search_key);
    assign key_live   = (key_reg != EMPTY_KEY);

    assign stat.is_count  = (command == CMD_COUNT);
    assign stat.scan_done = match || (!pend_reg && (addr_reg >= fill_reg));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Capture the command and walk the scan address.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cmd_reg <= command;
            key_reg <= entry_key;
            val_reg <= entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (ctrl.scan_en)
        begin
            pend_reg <= issue;
            if (issue)
            begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (match)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            addr_p_reg <= addr_reg[AW-1:0];
        end
        if (ctrl.scan_en && match)
        begin
            idx_reg       <= addr_p_reg;
            val_found_reg <= val_rd_reg;
        end
    end

    // Table memories: one registered read port, one write port.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            key_rd_reg <= key_mem[addr_reg[AW-1:0]];
            val_rd_reg <= val_mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    // Commit: write the slot, adjust fill and live counts, build the result.
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_key          = key_reg;
        wr_val          = val_reg;
        fill_next       = fill_reg;
        live_next       = live_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (found_reg)
                begin
                    wr_en     = ctrl.commit;
                    live_next = live_reg + CW'(key_live);
                end
                else if (fill_reg < DEPTH_C)
                begin
                    wr_en     = ctrl.commit;
                    wr_addr   = fill_reg[AW-1:0];
                    fill_next = fill_reg + CW'(1);
                    live_next = live_reg + CW'(key_live);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (found_reg)
                begin
                    wr_en     = ctrl.commit;
                    wr_key    = EMPTY_KEY;
                    wr_val    = '0;
                    live_next = live_reg - CW'(key_live);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP:
            begin
                if (found_reg)
                begin
                    read_value_next = val_found_reg;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            fill_reg      <= fill_next;
            live_reg      <= live_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            live_count_reg <= LIVE_W'(live_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign live_count = live_count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill level above table depth");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= fill_reg)
        else $error("live count above fill level");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    a_pend_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (CW'(addr_p_reg) < fill_reg))
        else $error("scan read at or above fill level");

endmodule
